### hdl/pidsb_pkg.sv
package pidsb_pkg;

	localparam int COLUMN_BITS_DEF    = 10;
	localparam int GAIN_FRAC_BITS_DEF = 16;

	localparam int GAIN_W     = 24;
	localparam int SUM_W      = 32;
	localparam int DIST_W     = 16;
	localparam int STEER_W    = 16;
	localparam int THR_W      = 16;
	localparam int OUT_DATA_W = STEER_W + THR_W;
	localparam int ACC_W      = 64;
	localparam int FRAC_OUT   = 14;
	localparam int STEER_HALF = 16384;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET = 3'd0,
		REG_PROP   = 3'd1,
		REG_INTEG  = 3'd2,
		REG_DERIV  = 3'd3,
		REG_CRUISE = 3'd4,
		REG_BRAKE  = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		OP_TRACK = 1'b0,
		OP_DIST  = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
	} pidsb_gains_t;

endpackage

### hdl/pid_steering_with_brake_gate_top.sv
// Channel   Dir  Payload                                       Notes
// s_*       in   tdata: column, distance; tuser: opcode         0 track, 1 distance
// m_*       out  tdata: steer, throttle                         one per track request
// cfg_*     in   cfg_idx selects register, cfg_wdata value      write only
//
// A track request is registered in stage one, stage two and the output register in turn.
// Accepts one request per cycle unless stalled; three gain multipliers work in parallel in one stage.
// Distance requests update the stop flag at acceptance and give no result.
// Reset clears the error sum, previous error, stop flag, config registers and valid flags.
// Input requests are held off only when every pipeline stage is full and the output is stalled.
module pid_steering_with_brake_gate_top #(
	parameter  int COLUMN_BITS    = pidsb_pkg::COLUMN_BITS_DEF,
	parameter  int GAIN_FRAC_BITS = pidsb_pkg::GAIN_FRAC_BITS_DEF,
	localparam int IN_DATA_W      = ((COLUMN_BITS + pidsb_pkg::DIST_W + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [IN_DATA_W-1:0]                 s_tdata,   // column, distance, zero pad
	input  logic                                 s_tuser,   // opcode
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [pidsb_pkg::OUT_DATA_W-1:0]     m_tdata,   // steer, throttle
	input  logic                                 cfg_we,
	input  logic [pidsb_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [pidsb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import pidsb_pkg::*;

	logic [COLUMN_BITS-1:0] target_q;
	pidsb_gains_t           gains_q;
	logic [THR_W-1:0]       cruise_q;
	logic [DIST_W-1:0]      brake_q;
	logic                   stop_q;

	logic [COLUMN_BITS-1:0] column;
	logic [DIST_W-1:0]      distance;
	logic                   track_req;
	logic                   dist_acc;
	logic [THR_W-1:0]       thr_in;
	logic                   core_ready;
	logic signed [STEER_W-1:0] steer;
	logic [THR_W-1:0]       throttle;

	assign column    = s_tdata[COLUMN_BITS-1:0];
	assign distance  = s_tdata[COLUMN_BITS +: DIST_W];
	assign s_tready  = core_ready;
	assign track_req = s_tvalid && (opcode_t'(s_tuser) == OP_TRACK);
	assign dist_acc  = s_tvalid && s_tready && (opcode_t'(s_tuser) == OP_DIST);
	assign thr_in    = stop_q ? '0 : cruise_q;
	assign m_tdata   = {throttle, steer};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			gains_q  <= '0;
			cruise_q <= '0;
			brake_q  <= '0;
			stop_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_TARGET: target_q   <= cfg_wdata[COLUMN_BITS-1:0];
					REG_PROP:   gains_q.kp <= cfg_wdata[GAIN_W-1:0];
					REG_INTEG:  gains_q.ki <= cfg_wdata[GAIN_W-1:0];
					REG_DERIV:  gains_q.kd <= cfg_wdata[GAIN_W-1:0];
					REG_CRUISE: cruise_q   <= cfg_wdata[THR_W-1:0];
					REG_BRAKE:  brake_q    <= cfg_wdata[DIST_W-1:0];
					default: begin
					end
				endcase
			end
			if (dist_acc) begin
				stop_q <= distance < brake_q;
			end
		end
	end

	pidsb_core #(
		.COLUMN_BITS   (COLUMN_BITS),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (track_req),
		.in_ready   (core_ready),
		.column     (column),
		.target     (target_q),
		.gains      (gains_q),
		.throttle_in(thr_in),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.steer      (steer),
		.throttle   (throttle)
	);

endmodule

### hdl/pidsb_core.sv
module pidsb_core #(
	parameter int COLUMN_BITS    = pidsb_pkg::COLUMN_BITS_DEF,
	parameter int GAIN_FRAC_BITS = pidsb_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [COLUMN_BITS-1:0]              column,
	input  logic [COLUMN_BITS-1:0]              target,
	input  pidsb_pkg::pidsb_gains_t             gains,
	input  logic [pidsb_pkg::THR_W-1:0]         throttle_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pidsb_pkg::STEER_W-1:0] steer,
	output logic [pidsb_pkg::THR_W-1:0]         throttle
);
	import pidsb_pkg::*;

	localparam int EW  = COLUMN_BITS + 1;
	localparam int DW  = COLUMN_BITS + 2;
	localparam int PW  = GAIN_W + EW;
	localparam int IPW = GAIN_W + SUM_W;
	localparam int DPW = GAIN_W + DW;
	localparam int VW  = GAIN_FRAC_BITS + 2;
	localparam logic signed [ACC_W-1:0] ONE = ACC_W'(1) << GAIN_FRAC_BITS;

	logic rdy_s2, rdy_out;
	logic v_s1, v_s2;

	// Controller state.
	logic signed [SUM_W-1:0] sum_q;
	logic signed [EW-1:0]    last_q;

	logic signed [EW-1:0]    e_c;
	logic signed [SUM_W:0]   s_wide_c;
	logic signed [SUM_W-1:0] s_c;
	logic signed [DW-1:0]    d_c;

	logic signed [EW-1:0]    e_s1;
	logic signed [SUM_W-1:0] s_s1;
	logic signed [DW-1:0]    d_s1;
	logic [THR_W-1:0]        thr_s1;

	logic signed [PW-1:0]    p_c;
	logic signed [IPW-1:0]   i_c;
	logic signed [DPW-1:0]   dp_c;
	logic signed [PW-1:0]    p_s2;
	logic signed [IPW-1:0]   i_s2;
	logic signed [DPW-1:0]   dp_s2;
	logic [THR_W-1:0]        thr_s2;

	logic signed [ACC_W-1:0] acc_c;
	logic signed [ACC_W-1:0] clip_c;
	logic signed [ACC_W-1:0] shift_c;
	logic [VW-1:0]           v_c;
	logic [STEER_W-1:0]      w_c;
	logic [STEER_W-1:0]      steer_c;

	assign rdy_out  = !out_valid || out_ready;
	assign rdy_s2   = !v_s2 || rdy_out;
	assign in_ready = !v_s1 || rdy_s2;

	assign e_c      = $signed({1'b0, target}) - $signed({1'b0, column});
	assign s_wide_c = $signed({sum_q[SUM_W-1], sum_q}) + (SUM_W+1)'(e_c);
	assign d_c      = DW'(e_c) - DW'(last_q);

	always_comb begin
		if (s_wide_c[SUM_W] != s_wide_c[SUM_W-1]) begin
			s_c = s_wide_c[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			s_c = s_wide_c[SUM_W-1:0];
		end
	end

	assign p_c  = $signed(gains.kp) * e_s1;
	assign i_c  = $signed(gains.ki) * s_s1;
	assign dp_c = $signed(gains.kd) * d_s1;

	assign acc_c = ACC_W'(p_s2) + ACC_W'(i_s2) + ACC_W'(dp_s2);

	always_comb begin
		if (acc_c > ONE) begin
			clip_c = ONE;
		end else if (acc_c < -ONE) begin
			clip_c = -ONE;
		end else begin
			clip_c = acc_c;
		end
	end

	// Offset to a non-negative value so that rounding is a plain add and shift;
	// ties then go toward +infinity on the unnegated output.
	assign shift_c = clip_c + ONE;
	assign v_c     = shift_c[VW-1:0];

	generate
		if (GAIN_FRAC_BITS > FRAC_OUT) begin : g_round
			localparam int RND = 1 << (GAIN_FRAC_BITS - FRAC_OUT - 1);
			logic [VW-1:0] vr_c;
			assign vr_c = v_c + VW'(RND);
			assign w_c  = vr_c[VW-1:GAIN_FRAC_BITS-FRAC_OUT];
		end else if (GAIN_FRAC_BITS == FRAC_OUT) begin : g_same
			assign w_c = v_c;
		end else begin : g_widen
			assign w_c = {v_c, {(FRAC_OUT-GAIN_FRAC_BITS){1'b0}}};
		end
	endgenerate

	assign steer_c = STEER_W'(STEER_HALF) - w_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			last_q    <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				sum_q  <= s_c;
				last_q <= e_c;
			end
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_out) begin
				out_valid <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			e_s1   <= e_c;
			s_s1   <= s_c;
			d_s1   <= d_c;
			thr_s1 <= throttle_in;
		end
		if (rdy_s2) begin
			p_s2   <= p_c;
			i_s2   <= i_c;
			dp_s2  <= dp_c;
			thr_s2 <= thr_s1;
		end
		if (rdy_out) begin
			steer    <= steer_c;
			throttle <= thr_s2;
		end
	end

endmodule

### hdl/pidsb_checker.sv
module pidsb_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [pidsb_pkg::OUT_DATA_W-1:0] m_tdata
);
	import pidsb_pkg::*;

	// A stalled result keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[STEER_W-1:0]) >= -16'sd16384) &&
		             ($signed(m_tdata[STEER_W-1:0]) <= 16'sd16384))
		else $error("steer outside full scale");

	// Input is held off only behind a stalled output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// A track request reaches the output when the output drains while it moves through the pipeline.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (opcode_t'(s_tuser) == OP_TRACK)) ##1 m_tready ##1 m_tready
		|=> m_tvalid)
		else $error("track result missing");

endmodule

bind pid_steering_with_brake_gate_top pidsb_checker u_pidsb_checker (.*);
